### design/vmr_pkg.sv
// Shared types, constants and the control program for the vibration magnitude block.
// Used by vmr_seq, vmr_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vmr_pkg;

   // Significant bits of each raw axis; the rest of the field is ignored.
   localparam int SAMPLE_BITS = 16;

   localparam logic [11:0] WINDOW_RESET = 12'd500;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic [15:0] magnitude;
      logic        window_done;
      logic [15:0] rms_value;
      logic [15:0] peak_to_peak;
   } rsp_type;

   // Multiplier operand sources.
   localparam logic [1:0] MUL_X    = 2'd0;
   localparam logic [1:0] MUL_Y    = 2'd1;
   localparam logic [1:0] MUL_Z    = 2'd2;
   localparam logic [1:0] MUL_ROOT = 2'd3;

   // Square accumulator operations.
   localparam logic [1:0] SQ_HOLD = 2'd0;
   localparam logic [1:0] SQ_LOAD = 2'd1;
   localparam logic [1:0] SQ_ADD  = 2'd2;

   // Square root unit operations.
   localparam logic [1:0] RT_HOLD     = 2'd0;
   localparam logic [1:0] RT_LOAD_SQ  = 2'd1;
   localparam logic [1:0] RT_LOAD_QUO = 2'd2;
   localparam logic [1:0] RT_STEP     = 2'd3;

   // Sequencer conditions.
   localparam logic [2:0] COND_NEXT     = 3'd0;
   localparam logic [2:0] COND_WAIT_IN  = 3'd1;
   localparam logic [2:0] COND_LOOP     = 3'd2;
   localparam logic [2:0] COND_OPEN_JMP = 3'd3;
   localparam logic [2:0] COND_WAIT_OUT = 3'd4;

   // Program steps.
   localparam logic [3:0] STEP_IDLE     = 4'd0;
   localparam logic [3:0] STEP_MUL_X    = 4'd1;
   localparam logic [3:0] STEP_MUL_Y    = 4'd2;
   localparam logic [3:0] STEP_MUL_Z    = 4'd3;
   localparam logic [3:0] STEP_ADD_Z    = 4'd4;
   localparam logic [3:0] STEP_RT_LOAD  = 4'd5;
   localparam logic [3:0] STEP_RT_LOOP  = 4'd6;
   localparam logic [3:0] STEP_MAG_SQ   = 4'd7;
   localparam logic [3:0] STEP_STATS    = 4'd8;
   localparam logic [3:0] STEP_DIV_LOOP = 4'd9;
   localparam logic [3:0] STEP_RMS_LOAD = 4'd10;
   localparam logic [3:0] STEP_RMS_LOOP = 4'd11;
   localparam logic [3:0] STEP_OUT      = 4'd12;

   localparam logic [4:0] ITER_SQRT = 5'd15;
   localparam logic [4:0] ITER_DIV  = 5'd31;

   typedef struct packed {
      logic [1:0] mul_src;
      logic       mul_en;
      logic [1:0] sq_op;
      logic [1:0] rt_op;
      logic       stat_en;
      logic       div_step;
      logic       iter_en;
      logic [4:0] iter_val;
      logic [2:0] cond;
      logic [3:0] target;
   } ucode_type;

   // Datapath controls for one cycle.
   typedef struct packed {
      logic [1:0] mul_src;
      logic       mul_en;
      logic [1:0] sq_op;
      logic [1:0] rt_op;
      logic       stat_en;
      logic       div_step;
      logic       capture;
   } dp_ctrl_type;

   function automatic ucode_type ucode_rom(logic [3:0] addr);
      ucode_type w;
      w = '0;
      unique case (addr)
         STEP_IDLE: begin
            w.cond = COND_WAIT_IN;
         end
         STEP_MUL_X: begin
            w.mul_en  = 1'b1;
            w.mul_src = MUL_X;
         end
         STEP_MUL_Y: begin
            w.mul_en  = 1'b1;
            w.mul_src = MUL_Y;
            w.sq_op   = SQ_LOAD;
         end
         STEP_MUL_Z: begin
            w.mul_en  = 1'b1;
            w.mul_src = MUL_Z;
            w.sq_op   = SQ_ADD;
         end
         STEP_ADD_Z: begin
            w.sq_op = SQ_ADD;
         end
         STEP_RT_LOAD: begin
            w.rt_op    = RT_LOAD_SQ;
            w.iter_en  = 1'b1;
            w.iter_val = ITER_SQRT;
         end
         STEP_RT_LOOP: begin
            w.rt_op = RT_STEP;
            w.cond  = COND_LOOP;
         end
         STEP_MAG_SQ: begin
            w.mul_en  = 1'b1;
            w.mul_src = MUL_ROOT;
         end
         STEP_STATS: begin
            w.stat_en  = 1'b1;
            w.iter_en  = 1'b1;
            w.iter_val = ITER_DIV;
            w.cond     = COND_OPEN_JMP;
            w.target   = STEP_OUT;
         end
         STEP_DIV_LOOP: begin
            w.div_step = 1'b1;
            w.cond     = COND_LOOP;
         end
         STEP_RMS_LOAD: begin
            w.rt_op    = RT_LOAD_QUO;
            w.iter_en  = 1'b1;
            w.iter_val = ITER_SQRT;
         end
         STEP_RMS_LOOP: begin
            w.rt_op = RT_STEP;
            w.cond  = COND_LOOP;
         end
         STEP_OUT: begin
            w.cond   = COND_WAIT_OUT;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_WAIT_OUT;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/vibration_magnitude_rms_p2p_top.sv
// Each accepted transaction runs the program to its result, and one that closes a window
// also runs the division and the RMS root. A new one is taken once the last result is written;
// the root and the bit-serial divider take one bit per cycle under the microcode sequencer.
// Reset clears the window (count zero) and sets the window length to 500.
// Depends on vmr_pkg, vmr_seq and vmr_dp.
`timescale 1ns / 1ps
`default_nettype none

module vibration_magnitude_rms_p2p_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire vmr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output vmr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [11:0]      csr_data
);
   import vmr_pkg::*;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic [11:0] wlen_ff;
   logic        slot_free;
   logic        rsp_write;
   logic        closing;
   dp_ctrl_type dp_ctrl;
   rsp_type     rsp_next;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   vmr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .slot_free (slot_free),
      .closing   (closing),
      .req_ready (req_ready),
      .rsp_write (rsp_write),
      .dp_ctrl   (dp_ctrl)
   );

   vmr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_ctrl       (dp_ctrl),
      .req_data      (req_data),
      .window_length (wlen_ff),
      .closing       (closing),
      .rsp_next      (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         wlen_ff <= csr_data;
      end
   end

   // The result register frees the datapath to take the next transaction at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write) begin
         rsp_data_ff <= rsp_next;
      end
   end

endmodule

`default_nettype wire

### design/vmr_seq.sv
// Microcode sequencer: program counter, loop counter and control word decode.
// Depends on vmr_pkg for the program table and control types.
`timescale 1ns / 1ps
`default_nettype none

module vmr_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 slot_free,
   input  wire logic                 closing,
   output logic                      req_ready,
   output logic                      rsp_write,
   output vmr_pkg::dp_ctrl_type      dp_ctrl
);
   import vmr_pkg::*;

   logic [3:0] pc_ff, pc_in;
   logic [4:0] iter_ff, iter_in;
   ucode_type  word;

   assign word = ucode_rom(pc_ff);

   assign req_ready = (word.cond == COND_WAIT_IN);
   assign rsp_write = (word.cond == COND_WAIT_OUT) && slot_free;

   always_comb begin
      dp_ctrl.mul_src  = word.mul_src;
      dp_ctrl.mul_en   = word.mul_en;
      dp_ctrl.sq_op    = word.sq_op;
      dp_ctrl.rt_op    = word.rt_op;
      dp_ctrl.stat_en  = word.stat_en;
      dp_ctrl.div_step = word.div_step;
      dp_ctrl.capture  = req_valid && req_ready;
   end

   always_comb begin
      pc_in = 4'(pc_ff + 4'd1);
      unique case (word.cond)
         COND_NEXT:     pc_in = 4'(pc_ff + 4'd1);
         COND_WAIT_IN:  if (!req_valid) pc_in = pc_ff;
         COND_LOOP:     if (iter_ff != 5'd0) pc_in = pc_ff;
         // A sample that leaves the window open skips the division and the RMS root.
         COND_OPEN_JMP: if (!closing) pc_in = word.target;
         COND_WAIT_OUT: pc_in = slot_free ? word.target : pc_ff;
         default:       pc_in = STEP_IDLE;
      endcase
   end

   always_comb begin
      iter_in = iter_ff;
      if (word.iter_en) begin
         iter_in = word.iter_val;
      end else if (word.cond == COND_LOOP && iter_ff != 5'd0) begin
         iter_in = 5'(iter_ff - 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_IDLE;
         iter_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         iter_ff <= iter_in;
      end
   end

endmodule

`default_nettype wire

### design/vmr_dp.sv
// Datapath: input capture, shared multiplier, square root and divider units, window statistics.
// Depends on vmr_pkg; driven cycle by cycle by vmr_seq.
`timescale 1ns / 1ps
`default_nettype none

module vmr_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vmr_pkg::dp_ctrl_type dp_ctrl,
   input  wire vmr_pkg::req_type     req_data,
   input  wire logic [11:0]          window_length,
   output logic                      closing,
   output vmr_pkg::rsp_type          rsp_next
);
   import vmr_pkg::*;

   function automatic logic [15:0] axis_abs(logic signed [15:0] raw);
      logic signed [SAMPLE_BITS-1:0] v;
      logic signed [15:0]            s;
      v = raw[SAMPLE_BITS-1:0];
      s = 16'(v);
      return s[15] ? 16'(-s) : 16'(s);
   endfunction

   req_type     req_ff;
   logic [31:0] prod_ff;
   logic [31:0] sq_ff;
   logic [31:0] rad_ff;
   logic [16:0] rem_ff;
   logic [15:0] root_ff;
   logic [15:0] mag_ff;
   logic [43:0] sum_ff;
   logic [15:0] min_ff;
   logic [15:0] max_ff;
   logic [15:0] p2p_ff;
   logic [11:0] count_ff;
   logic [12:0] held_ff;
   logic [31:0] div_ff;
   logic [12:0] drem_ff;
   logic        done_ff;

   logic [15:0] mul_op;
   logic [18:0] rem_trial;
   logic [17:0] root_trial;
   logic        rt_ge;
   logic [13:0] div_trial;
   logic        div_ge;
   logic [11:0] len;
   logic [12:0] held;
   logic        first;
   logic [15:0] min_new;
   logic [15:0] max_new;
   logic [43:0] sum_new;

   always_comb begin
      case (dp_ctrl.mul_src)
         MUL_X:   mul_op = axis_abs(req_ff.accel_x);
         MUL_Y:   mul_op = axis_abs(req_ff.accel_y);
         MUL_Z:   mul_op = axis_abs(req_ff.accel_z);
         default: mul_op = root_ff;
      endcase
   end

   // One result bit per step: two radicand bits enter the partial remainder.
   assign rem_trial  = {rem_ff, rad_ff[31:30]};
   assign root_trial = {root_ff, 2'b01};
   assign rt_ge      = rem_trial >= {1'b0, root_trial};

   // The top word of the sum is always below the sample count, so the quotient fits 32 bits.
   assign div_trial = {drem_ff, div_ff[31]};
   assign div_ge    = div_trial >= {1'b0, held_ff};

   assign len     = (window_length == 12'd0) ? 12'd1 : window_length;
   assign held    = 13'({1'b0, count_ff} + 13'd1);
   assign first   = (count_ff == 12'd0);
   assign closing = held >= {1'b0, len};
   assign min_new = (first || mag_ff < min_ff) ? mag_ff : min_ff;
   assign max_new = (first || mag_ff > max_ff) ? mag_ff : max_ff;
   assign sum_new = 44'((first ? 44'd0 : sum_ff) + {12'd0, prod_ff});

   always_comb begin
      rsp_next.magnitude    = mag_ff;
      rsp_next.window_done  = done_ff;
      rsp_next.rms_value    = done_ff ? root_ff : 16'd0;
      rsp_next.peak_to_peak = done_ff ? p2p_ff : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (dp_ctrl.capture) begin
         req_ff <= req_data;
      end
      if (dp_ctrl.mul_en) begin
         prod_ff <= mul_op * mul_op;
      end
      case (dp_ctrl.sq_op)
         SQ_LOAD: sq_ff <= prod_ff;
         SQ_ADD:  sq_ff <= sq_ff + prod_ff;
         default: sq_ff <= sq_ff;
      endcase
      case (dp_ctrl.rt_op)
         RT_LOAD_SQ: begin
            rad_ff  <= sq_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         RT_LOAD_QUO: begin
            rad_ff  <= div_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         RT_STEP: begin
            rad_ff  <= {rad_ff[29:0], 2'b00};
            rem_ff  <= rt_ge ? 17'(rem_trial - {1'b0, root_trial}) : rem_trial[16:0];
            root_ff <= {root_ff[14:0], rt_ge};
         end
         default: begin
            rad_ff <= rad_ff;
         end
      endcase
      if (dp_ctrl.mul_en && dp_ctrl.mul_src == MUL_ROOT) begin
         mag_ff <= root_ff;
      end
      if (dp_ctrl.stat_en) begin
         min_ff  <= min_new;
         max_ff  <= max_new;
         p2p_ff  <= max_new - min_new;
         done_ff <= closing;
         held_ff <= held;
         div_ff  <= sum_new[31:0];
         drem_ff <= {1'b0, sum_new[43:32]};
      end else if (dp_ctrl.div_step) begin
         div_ff  <= {div_ff[30:0], div_ge};
         drem_ff <= div_ge ? 13'(div_trial - {1'b0, held_ff}) : div_trial[12:0];
      end
   end

   // Window control state; the first sample of a window ignores the held sum and extremes.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (dp_ctrl.stat_en) begin
         count_ff <= closing ? 12'd0 : held[11:0];
         sum_ff   <= closing ? 44'd0 : sum_new;
      end
   end

endmodule

`default_nettype wire
